// ===== hw/rtl/catchup_tick_scheduler_core_assert.svh =====
// assertion macros for the catchup tick scheduler
`ifndef CATCHUP_TICK_SCHEDULER_CORE_ASSERT_SVH
`define CATCHUP_TICK_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Types, codes and helpers shared by the catchup tick scheduler.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivCntW = 6;

  typedef logic [TimeW-1:0] time_t;

  // request kinds
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_TICK_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NOTIFY_INTERVAL = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_DIV,
    ST_ADJ1,
    ST_ADJ2,
    ST_ADJ3,
    ST_NCMP,
    ST_NARM,
    ST_WT1,
    ST_WT2,
    ST_WT3
  } cts_state_t;

  // a zero period acts as one
  function automatic time_t nonzero_period(input time_t p);
    nonzero_period = (p == '0) ? time_t'(1) : p;
  endfunction

endpackage

// ===== hw/rtl/catchup_tick_scheduler_core.sv =====
// update: when ticks are due, the overdue time is divided by the tick
// period; the notification re-arms when due or on fast_forward. restart:
// next_tick takes now_us and the notification re-arms. a new item is taken
// only after the result is registered. the radix-2 restoring divide runs 64
// steps on the one shared 65-bit add/subtract unit. synchronous reset loads
// tick_interval 1000, notify_interval 1000000 and both deadlines zero.
// ----------------------------------------------------------------------------
// catchup_tick_scheduler_core
// Fixed-timestep scheduler with catch-up: counts due ticks by division,
// fires and re-arms notifications, reports zero on fast_forward, else time to the nearer deadline.
// ----------------------------------------------------------------------------
module catchup_tick_scheduler_core
  import cts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  time_t              cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  time_t              now_us,
  input  logic               fast_forward,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output time_t              ticks_due,
  output logic               notify_due,
  output time_t              wait_us
);

  cts_state_t state, state_next;

  time_t tick_interval;
  time_t notify_interval;
  time_t next_tick;
  time_t next_notify;
  time_t cur_now;
  logic  cur_ff;
  time_t period;
  time_t nper;
  time_t rem;
  time_t quo;
  time_t ticks;
  logic  fire;
  time_t left_a;
  time_t left_b;
  logic [DivCntW-1:0] div_cnt;

  logic in_take;
  logic out_load;

  // shared add/subtract unit
  logic [TimeW:0]   op_a;
  logic [TimeW:0]   op_b;
  logic             op_sub;
  logic [TimeW+1:0] sum;
  logic             ge;
  time_t            res;
  time_t            wait_min;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_load = (state == ST_WT3) && (!out_valid || !out_stall);

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_sub = 1'b1;
    case (state)
      ST_SUB: begin
        op_a = {1'b0, cur_now};
        op_b = {1'b0, next_tick};
      end
      ST_DIV: begin
        op_a = {rem, quo[TimeW-1]};
        op_b = {1'b0, period};
      end
      ST_ADJ1: begin
        op_a = {1'b0, quo};
        op_b = (TimeW+1)'(1);
        op_sub = 1'b0;
      end
      ST_ADJ2: begin
        op_a = {1'b0, cur_now};
        op_b = {1'b0, rem};
      end
      ST_ADJ3: begin
        op_a = {1'b0, next_tick};
        op_b = {1'b0, period};
        op_sub = 1'b0;
      end
      ST_NCMP: begin
        op_a = {1'b0, cur_now};
        op_b = {1'b0, next_notify};
      end
      ST_NARM: begin
        op_a = {1'b0, cur_now};
        op_b = {1'b0, nper};
        op_sub = 1'b0;
      end
      ST_WT1: begin
        op_a = {1'b0, next_tick};
        op_b = {1'b0, cur_now};
      end
      ST_WT2: begin
        op_a = {1'b0, next_notify};
        op_b = {1'b0, cur_now};
      end
      ST_WT3: begin
        op_a = {1'b0, left_a};
        op_b = {1'b0, left_b};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (TimeW+2)'(op_sub);
  assign ge = sum[TimeW+1];
  assign res = sum[TimeW-1:0];
  assign wait_min = ge ? left_b : left_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = (req_type == REQ_UPDATE) ? ST_SUB : ST_NARM;
        end
      end
      ST_SUB:  state_next = ge ? ST_DIV : ST_NCMP;
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_ADJ1;
        end
      end
      ST_ADJ1: state_next = ST_ADJ2;
      ST_ADJ2: state_next = ST_ADJ3;
      ST_ADJ3: state_next = ST_NCMP;
      ST_NCMP: state_next = (cur_ff || ge) ? ST_NARM : ST_WT1;
      ST_NARM: state_next = ST_WT1;
      ST_WT1:  state_next = ST_WT2;
      ST_WT2:  state_next = ST_WT3;
      ST_WT3: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers and deadlines
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_interval <= time_t'(1000);
      notify_interval <= time_t'(1000000);
      next_tick <= '0;
      next_notify <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TICK_INTERVAL:   tick_interval <= cfg_data;
          CFG_NOTIFY_INTERVAL: notify_interval <= cfg_data;
          default: ;
        endcase
      end
      if (in_take && req_type == REQ_RESTART) begin
        next_tick <= now_us;
      end
      if (state == ST_ADJ2) begin
        next_tick <= res;
      end else if (state == ST_ADJ3) begin
        next_tick <= res;
      end
      if (state == ST_NARM) begin
        next_notify <= res;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_now <= now_us;
      cur_ff <= fast_forward;
      period <= nonzero_period(tick_interval);
      nper <= nonzero_period(notify_interval);
      ticks <= '0;
      fire <= 1'b0;
    end
    case (state)
      ST_SUB: begin
        // dividend is the overdue time, remainder starts empty
        quo <= res;
        rem <= '0;
        div_cnt <= DivCntW'(TimeW - 1);
      end
      ST_DIV: begin
        rem <= ge ? res : op_a[TimeW-1:0];
        quo <= {quo[TimeW-2:0], ge};
        div_cnt <= div_cnt - DivCntW'(1);
      end
      ST_ADJ1: ticks <= res;
      ST_NCMP: fire <= cur_ff || ge;
      ST_WT1:  left_a <= ge ? res : '0;
      ST_WT2:  left_b <= ge ? res : '0;
      default: ;
    endcase
  end

  // result register; next_tick + ticks * period folds to now - rem + period
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ticks_due <= ticks;
      notify_due <= fire;
      wait_us <= cur_ff ? '0 : wait_min;
    end
  end

`include "catchup_tick_scheduler_core_assert.svh"

  `CTS_ASSERT_NEXT(a_update_starts_diff, in_take && req_type == REQ_UPDATE, state == ST_SUB, "update did not start with the overdue subtract")
  `CTS_ASSERT_NEXT(a_restart_rearms, in_take && req_type == REQ_RESTART, state == ST_NARM, "restart did not re-arm the notification")
  `CTS_ASSERT_NEXT(a_div_ends, state == ST_DIV && div_cnt == '0, state == ST_ADJ1, "divide loop ran past 64 steps")
  `CTS_ASSERT_NOW(a_rem_bound, state == ST_ADJ1, rem < period, "divide remainder not below period")

endmodule
